// ===== rtl/brat_pkg.sv =====
`default_nettype none
package brat_pkg;

	localparam int unsigned W  = 32;            // value width
	localparam int unsigned PW = 3 * W;         // widest exact product
	localparam int unsigned CW = $clog2(W + 1); // iteration counter width

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DIV  = 2'd1,
		PH_SCAN = 2'd2,
		PH_CONV = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NOFRAC = 2'd0,
		KIND_SEMI   = 2'd1,
		KIND_CONV   = 2'd2
	} kind_t;

	// products formed one after another for a tick
	typedef enum logic [2:0] {
		SEL_PN = 3'd0,  // k*p1 + p0
		SEL_QN = 3'd1,  // k*q1 + q0
		SEL_T1 = 3'd2,  // qn*num
		SEL_L  = 3'd3,  // den*pn, then |t1 - den*pn|
		SEL_T3 = 3'd4,  // q1*num
		SEL_R  = 3'd5,  // den*p1, then |t3 - den*p1|
		SEL_BL = 3'd6,  // l*q1
		SEL_BR = 3'd7   // r*qn, then compare
	} mul_sel_t;

	typedef struct packed {
		logic     ld;
		logic     div_go;
		logic     div_fin;
		logic     mul_go;
		logic     mul_cap;
		mul_sel_t sel;
		logic     use_pq;
		logic     scan_adv;
		logic     conv_commit;
		logic     out_load;
		kind_t    kind;
	} cmd_t;

	typedef struct packed {
		logic rem_den_zero;
		logic div_done;
		logic mul_done;
		logic bad;
		logic better;
		logic cand_last;
		logic pq_nz;
		logic past_first;
		logic rmd_zero;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/brat_in_if.sv =====
`default_nettype none
interface brat_in_if;
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic [brat_pkg::W-1:0]  numerator;
	logic [brat_pkg::W-1:0]  denominator;

	modport source (output valid, cmd, numerator, denominator, input ready);
	modport sink   (input valid, cmd, numerator, denominator, output ready);
endinterface
`default_nettype wire

// ===== rtl/brat_out_if.sv =====
`default_nettype none
interface brat_out_if;
	logic                    valid;
	logic                    ready;
	logic [brat_pkg::W-1:0]  frac_num;
	logic [brat_pkg::W-1:0]  frac_den;
	logic                    has_fraction;
	logic                    is_convergent;
	logic                    final_res;

	modport source (output valid, frac_num, frac_den, has_fraction, is_convergent, final_res,
		input ready);
	modport sink   (input valid, frac_num, frac_den, has_fraction, is_convergent, final_res,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/brat_cfg_if.sv =====
`default_nettype none
interface brat_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [31:0]             limit;

	modport source (output valid, limit, input ready);
	modport sink   (input valid, limit, output ready);
endinterface
`default_nettype wire

// ===== rtl/brat_div.sv =====
`default_nettype none
module brat_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [brat_pkg::W-1:0]  num,
	input  logic [brat_pkg::W-1:0]  den,
	output logic                    done,
	output logic [brat_pkg::W-1:0]  quo,
	output logic [brat_pkg::W-1:0]  rmd
);
	logic                    busy_q;
	logic                    done_q;
	logic [brat_pkg::CW-1:0] cnt_q;
	logic [brat_pkg::W:0]    r_q;
	logic [brat_pkg::W-1:0]  q_q;
	logic [brat_pkg::W-1:0]  d_q;
	logic [brat_pkg::W:0]    r_sh;
	logic                    fits;

	// restoring division, one quotient bit per cycle
	assign r_sh = {r_q[brat_pkg::W-1:0], q_q[brat_pkg::W-1]};
	assign fits = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= brat_pkg::CW'(brat_pkg::W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == brat_pkg::CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			q_q <= num;
			d_q <= den;
		end else if (busy_q) begin
			r_q <= fits ? (r_sh - {1'b0, d_q}) : r_sh;
			q_q <= {q_q[brat_pkg::W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rmd  = r_q[brat_pkg::W-1:0];
endmodule
`default_nettype wire

// ===== rtl/brat_mul.sv =====
`default_nettype none
module brat_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*brat_pkg::W-1:0] mcand,
	input  logic [brat_pkg::W-1:0]   mplier,
	input  logic [brat_pkg::W-1:0]   addend,
	output logic                     done,
	output logic [brat_pkg::PW-1:0]  prod
);
	logic                    busy_q;
	logic                    done_q;
	logic [brat_pkg::CW-1:0] cnt_q;
	logic [brat_pkg::PW-1:0] acc_q;
	logic [brat_pkg::PW-1:0] mc_q;
	logic [brat_pkg::W-1:0]  mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= brat_pkg::CW'(brat_pkg::W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == brat_pkg::CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add, one multiplier bit per cycle, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= brat_pkg::PW'(addend);
			mc_q  <= brat_pkg::PW'(mcand);
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[brat_pkg::PW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[brat_pkg::W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== rtl/brat_dp.sv =====
`default_nettype none
module brat_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  brat_pkg::cmd_t          cmd,
	output brat_pkg::status_t       sts,
	input  logic [brat_pkg::W-1:0]  in_num,
	input  logic [brat_pkg::W-1:0]  in_den,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_limit,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [brat_pkg::W-1:0]  out_num,
	output logic [brat_pkg::W-1:0]  out_den,
	output logic                    out_has,
	output logic                    out_conv,
	output logic                    out_final
);
	localparam int unsigned W  = brat_pkg::W;
	localparam int unsigned PW = brat_pkg::PW;

	logic [31:0]   limit_q;
	logic [W-1:0]  onum_q, oden_q, rnum_q, rden_q;
	logic [W-1:0]  p0_q, q0_q, p1_q, q1_q;
	logic [W-1:0]  pq_q, cand_q, rmd_q;
	logic          past_first_q;
	logic [W-1:0]  pn_q, qn_q;
	logic          bad0_q, bad1_q, better_q;
	logic [2*W-1:0] t_q, l_q, r_q;
	logic [PW-1:0] bl_q;
	logic          ov_q;
	logic [W-1:0]  on_q, od_q;
	logic          oh_q, oc_q, of_q;

	logic          div_done;
	logic [W-1:0]  div_q, div_r;
	logic          mul_done;
	logic [PW-1:0] prod;
	logic [2*W-1:0] m_a;
	logic [W-1:0]  m_b, m_c, k;
	logic [W-1:0]  lim;
	logic          over;
	logic [2*W-1:0] p_lo;
	logic [W:0]    cand_nx;

	brat_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go), .num(rnum_q), .den(rden_q),
		.done(div_done), .quo(div_q), .rmd(div_r)
	);

	brat_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul_go), .mcand(m_a), .mplier(m_b),
		.addend(m_c), .done(mul_done), .prod(prod)
	);

	assign k       = cmd.use_pq ? pq_q : cand_q;
	assign lim     = (limit_q == '0) ? '1 : W'(limit_q);
	assign over    = prod > PW'(lim);
	assign p_lo    = prod[2*W-1:0];
	assign cand_nx = {1'b0, cand_q} + 1'b1;

	always_comb begin
		m_a = '0;
		m_b = '0;
		m_c = '0;
		case (cmd.sel)
			brat_pkg::SEL_PN: begin m_a = (2*W)'(p1_q); m_b = k;    m_c = p0_q; end
			brat_pkg::SEL_QN: begin m_a = (2*W)'(q1_q); m_b = k;    m_c = q0_q; end
			brat_pkg::SEL_T1: begin m_a = (2*W)'(onum_q); m_b = qn_q; end
			brat_pkg::SEL_L:  begin m_a = (2*W)'(oden_q); m_b = pn_q; end
			brat_pkg::SEL_T3: begin m_a = (2*W)'(onum_q); m_b = q1_q; end
			brat_pkg::SEL_R:  begin m_a = (2*W)'(oden_q); m_b = p1_q; end
			brat_pkg::SEL_BL: begin m_a = l_q; m_b = q1_q; end
			brat_pkg::SEL_BR: begin m_a = r_q; m_b = qn_q; end
			default: begin m_a = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= '0;
			onum_q       <= '0;
			oden_q       <= W'(1);
			rnum_q       <= '0;
			rden_q       <= W'(1);
			p0_q         <= '0;
			q0_q         <= W'(1);
			p1_q         <= W'(1);
			q1_q         <= '0;
			pq_q         <= '0;
			cand_q       <= '0;
			past_first_q <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_limit;
			end
			if (cmd.ld) begin
				onum_q       <= in_num;
				oden_q       <= in_den;
				rnum_q       <= in_num;
				rden_q       <= in_den;
				p0_q         <= '0;
				q0_q         <= W'(1);
				p1_q         <= W'(1);
				q1_q         <= '0;
				pq_q         <= '0;
				cand_q       <= '0;
				past_first_q <= 1'b0;
			end
			if (cmd.div_fin) begin
				pq_q   <= div_q;
				cand_q <= {1'b0, div_q[W-1:1]};
			end
			if (cmd.scan_adv && !sts.cand_last) begin
				cand_q <= cand_nx[W-1:0];
			end
			if (cmd.conv_commit) begin
				p0_q         <= p1_q;
				q0_q         <= q1_q;
				p1_q         <= pn_q;
				q1_q         <= qn_q;
				rnum_q       <= rden_q;
				rden_q       <= rmd_q;
				past_first_q <= 1'b1;
			end
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_fin) begin
			rmd_q <= div_r;
		end
		if (cmd.mul_cap) begin
			case (cmd.sel)
				brat_pkg::SEL_PN: begin pn_q <= prod[W-1:0]; bad0_q <= over; end
				brat_pkg::SEL_QN: begin qn_q <= prod[W-1:0]; bad1_q <= over; end
				brat_pkg::SEL_T1: t_q <= p_lo;
				brat_pkg::SEL_L:  l_q <= (t_q >= p_lo) ? (t_q - p_lo) : (p_lo - t_q);
				brat_pkg::SEL_T3: t_q <= p_lo;
				brat_pkg::SEL_R:  r_q <= (t_q >= p_lo) ? (t_q - p_lo) : (p_lo - t_q);
				brat_pkg::SEL_BL: bl_q <= prod;
				brat_pkg::SEL_BR: better_q <= bl_q < prod;
				default: t_q <= t_q;
			endcase
		end
		if (cmd.out_load) begin
			case (cmd.kind)
				brat_pkg::KIND_SEMI: begin
					on_q <= pn_q; od_q <= qn_q; oh_q <= 1'b1; oc_q <= 1'b0; of_q <= 1'b0;
				end
				brat_pkg::KIND_CONV: begin
					on_q <= pn_q; od_q <= qn_q; oh_q <= 1'b1; oc_q <= 1'b1;
					of_q <= (rden_q == '0);
				end
				default: begin
					on_q <= '0; od_q <= '0; oh_q <= 1'b0; oc_q <= 1'b0; of_q <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		sts.rem_den_zero = (rden_q == '0);
		sts.div_done     = div_done;
		sts.mul_done     = mul_done;
		sts.bad          = bad0_q | bad1_q;
		sts.better       = better_q;
		sts.cand_last    = !(cand_nx < {1'b0, pq_q});
		sts.pq_nz        = (pq_q != '0);
		sts.past_first   = past_first_q;
		sts.rmd_zero     = (rmd_q == '0);
		sts.out_free     = !ov_q || out_ready;
	end

	assign out_valid = ov_q;
	assign out_num   = on_q;
	assign out_den   = od_q;
	assign out_has   = oh_q;
	assign out_conv  = oc_q;
	assign out_final = of_q;
endmodule
`default_nettype wire

// ===== rtl/brat_ctrl.sv =====
`default_nettype none
module brat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_cmd,
	output logic              in_ready,
	input  brat_pkg::status_t sts,
	output brat_pkg::cmd_t    cmd
);
	typedef enum logic [5:0] {
		ST_READY = 6'b000001,
		ST_DWAIT = 6'b000010,
		ST_MGO   = 6'b000100,
		ST_MWAIT = 6'b001000,
		ST_DEC   = 6'b010000,
		ST_PUT   = 6'b100000
	} state_t;

	state_t             st_q, st_d;
	brat_pkg::phase_t   ph_q, ph_d;
	brat_pkg::mul_sel_t seq_q, seq_d;
	brat_pkg::kind_t    kind_q, kind_d;
	logic               acc;
	logic               last_mul;

	assign in_ready = (st_q == ST_READY);
	assign acc      = in_valid && in_ready;
	assign last_mul = (seq_q == brat_pkg::SEL_QN) || (seq_q == brat_pkg::SEL_BR);

	always_comb begin
		st_d   = st_q;
		ph_d   = ph_q;
		seq_d  = seq_q;
		kind_d = kind_q;
		cmd    = '0;
		cmd.sel    = seq_q;
		cmd.use_pq = (ph_q == brat_pkg::PH_CONV);
		cmd.kind   = kind_q;
		case (st_q)
			ST_READY: begin
				if (acc && !in_cmd) begin
					cmd.ld = 1'b1;
					ph_d   = brat_pkg::PH_DIV;
				end else if (acc) begin
					case (ph_q)
						brat_pkg::PH_DIV: begin
							if (sts.rem_den_zero) begin
								ph_d   = brat_pkg::PH_IDLE;
								kind_d = brat_pkg::KIND_NOFRAC;
								st_d   = ST_PUT;
							end else begin
								cmd.div_go = 1'b1;
								st_d       = ST_DWAIT;
							end
						end
						brat_pkg::PH_SCAN, brat_pkg::PH_CONV: begin
							seq_d = brat_pkg::SEL_PN;
							st_d  = ST_MGO;
						end
						default: st_d = ST_READY;
					endcase
				end
			end
			ST_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_fin = 1'b1;
					st_d        = ST_DEC;
				end
			end
			ST_MGO: begin
				cmd.mul_go = 1'b1;
				st_d       = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (sts.mul_done) begin
					cmd.mul_cap = 1'b1;
					if (last_mul) begin
						st_d = ST_DEC;
					end else begin
						seq_d = brat_pkg::mul_sel_t'(seq_q + 3'd1);
						st_d  = ST_MGO;
					end
				end
			end
			ST_DEC: begin
				st_d = ST_READY;
				case (ph_q)
					brat_pkg::PH_DIV: begin
						ph_d = (sts.past_first && sts.pq_nz) ? brat_pkg::PH_SCAN
							: brat_pkg::PH_CONV;
					end
					brat_pkg::PH_SCAN: begin
						if (seq_q == brat_pkg::SEL_QN) begin
							if (sts.bad) begin
								ph_d = brat_pkg::PH_CONV;
							end else begin
								seq_d = brat_pkg::SEL_T1;
								st_d  = ST_MGO;
							end
						end else begin
							cmd.scan_adv = 1'b1;
							if (sts.cand_last) begin
								ph_d = brat_pkg::PH_CONV;
							end
							if (sts.better) begin
								kind_d = brat_pkg::KIND_SEMI;
								st_d   = ST_PUT;
							end
						end
					end
					brat_pkg::PH_CONV: begin
						st_d = ST_PUT;
						if (sts.bad) begin
							ph_d   = brat_pkg::PH_IDLE;
							kind_d = brat_pkg::KIND_NOFRAC;
						end else begin
							cmd.conv_commit = 1'b1;
							ph_d   = sts.rmd_zero ? brat_pkg::PH_IDLE : brat_pkg::PH_DIV;
							kind_d = brat_pkg::KIND_CONV;
						end
					end
					default: st_d = ST_READY;
				endcase
			end
			ST_PUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					st_d         = ST_READY;
				end
			end
			default: st_d = ST_READY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_READY;
			ph_q   <= brat_pkg::PH_IDLE;
			seq_q  <= brat_pkg::SEL_PN;
			kind_q <= brat_pkg::KIND_NOFRAC;
		end else begin
			st_q   <= st_d;
			ph_q   <= ph_d;
			seq_q  <= seq_d;
			kind_q <= kind_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/best_rational_approximation.sv =====
// channel   dir  payload                                              transfer when
// in_ch     in   cmd, numerator, denominator                          valid && ready
// out_ch    out  frac_num, frac_den, has_fraction, is_convergent,     valid && ready
//                final_res
// cfg_ch    in   limit                                                valid && ready
//
// division tick: one quotient bit per cycle on the restoring divider
// each product is formed on the shared bit-serial shift-add multiplier
// convergent tick: pn and qn, then an emission; candidate over the limit:
// pn and qn only; semiconvergent test: every product, emitting when closer
// reset brings the expansion state to its start values and limit to 0 (no limit)
// a result waits in the output register; a new item is taken meanwhile, and only
// the next emission stalls until out_ch has moved the waiting one
`default_nettype none
module best_rational_approximation (
	input  logic       clk,
	input  logic       arst_n,
	brat_in_if.sink    in_ch,
	brat_out_if.source out_ch,
	brat_cfg_if.sink   cfg_ch
);
	brat_pkg::cmd_t    cmd;
	brat_pkg::status_t sts;
	logic              in_ready;

	// config register is always writable
	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = in_ready;

	// sequencer: tracks the expansion phase and steps the datapath
	brat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: convergent state, divider, multiplier, output register
	brat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_num    (in_ch.numerator),
		.in_den    (in_ch.denominator),
		.cfg_we    (cfg_ch.valid),
		.cfg_limit (cfg_ch.limit),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_num   (out_ch.frac_num),
		.out_den   (out_ch.frac_den),
		.out_has   (out_ch.has_fraction),
		.out_conv  (out_ch.is_convergent),
		.out_final (out_ch.final_res)
	);
endmodule
`default_nettype wire

// ===== verif/best_rational_approximation_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module best_rational_approximation_tb;

	localparam int unsigned W = brat_pkg::W;

	localparam int unsigned WATCHDOG_LIMIT = 20000;
	// longest tick is a semiconvergent test, 8 multiplies and an emission
	localparam int unsigned SETTLE_CYCLES  = 400;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef struct packed {
		logic         cmd;
		logic [W-1:0] numerator;
		logic [W-1:0] denominator;
	} ratio_item_t;

	typedef struct packed {
		logic [W-1:0] frac_num;
		logic [W-1:0] frac_den;
		logic         has_fraction;
		logic         is_convergent;
		logic         final_res;
	} approx_t;

	logic clk;
	logic arst_n;

	brat_in_if  in_ch ();
	brat_out_if out_ch ();
	brat_cfg_if cfg_ch ();

	best_rational_approximation DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	ratio_item_t pending_items[$];
	approx_t     expected_approx[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	// predictor state: a copy of the expansion registers
	logic [31:0]       lim_reg;
	logic [W-1:0]      x_num, x_den, r_num, r_den;
	logic [W-1:0]      p0, q0, p1, q1;
	logic [W-1:0]      pq, cand;
	brat_pkg::phase_t  x_phase;
	logic              x_past_first;

	// clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// k*m + c, exact
	function automatic logic [127:0] mul_add(input logic [W-1:0] k, m, c);
		return {96'd0, k} * {96'd0, m} + {96'd0, c};
	endfunction

	function automatic logic [127:0] abs_diff(input logic [127:0] a, b);
		return (a > b) ? a - b : b - a;
	endfunction

	// candidate pr/qr strictly closer to num/den than the last convergent
	function automatic logic closer(input logic [W-1:0] pr, qr);
		logic [127:0] t1, t2, t3;
		t1 = {96'd0, qr} * {96'd0, q1} * {96'd0, x_num};
		t2 = {96'd0, x_den} * {96'd0, q1} * {96'd0, pr};
		t3 = {96'd0, x_den} * {96'd0, qr} * {96'd0, p1};
		return abs_diff(t1, t2) < abs_diff(t1, t3);
	endfunction

	task automatic expansion_reset();
		lim_reg      = 32'd0;
		x_num        = '0;
		x_den        = 1;
		r_num        = '0;
		r_den        = 1;
		p0           = '0;
		q0           = 1;
		p1           = 1;
		q1           = '0;
		pq           = '0;
		cand         = '0;
		x_phase      = brat_pkg::PH_IDLE;
		x_past_first = 1'b0;
	endtask

	task automatic push_approx(input logic [W-1:0] n, d, input logic h, c, f);
		approx_t e;
		e.frac_num      = n;
		e.frac_den      = d;
		e.has_fraction  = h;
		e.is_convergent = c;
		e.final_res     = f;
		expected_approx.push_back(e);
	endtask

	// one accepted input item advances the expansion by one unit of work
	task automatic advance_expansion(input ratio_item_t it);
		logic [127:0] lim, pn, qn;
		logic [W-1:0] nr;
		lim = (lim_reg == 0) ? {96'd0, {W{1'b1}}} : {96'd0, lim_reg};
		if (it.cmd == CMD_LOAD) begin
			x_num        = it.numerator;
			x_den        = it.denominator;
			r_num        = it.numerator;
			r_den        = it.denominator;
			p0           = '0;
			q0           = 1;
			p1           = 1;
			q1           = '0;
			pq           = '0;
			cand         = '0;
			x_past_first = 1'b0;
			x_phase      = brat_pkg::PH_DIV;
		end else begin
			case (x_phase)
				brat_pkg::PH_DIV: begin
					if (r_den == 0) begin
						// zero denominator
						x_phase = brat_pkg::PH_IDLE;
						push_approx('0, '0, 1'b0, 1'b0, 1'b1);
					end else begin
						pq = r_num / r_den;
						if (x_past_first && pq >= 1) begin
							cand    = pq / 2;
							x_phase = brat_pkg::PH_SCAN;
						end else begin
							x_phase = brat_pkg::PH_CONV;
						end
					end
				end
				brat_pkg::PH_SCAN: begin
					pn = mul_add(cand, p1, p0);
					qn = mul_add(cand, q1, q0);
					if (pn > lim || qn > lim) begin
						// candidate over the limit ends the scan quietly
						x_phase = brat_pkg::PH_CONV;
					end else begin
						if ({1'b0, cand} + 1 < {1'b0, pq})
							cand = cand + 1;
						else
							x_phase = brat_pkg::PH_CONV;
						if (closer(pn[W-1:0], qn[W-1:0]))
							push_approx(pn[W-1:0], qn[W-1:0], 1'b1, 1'b0, 1'b0);
					end
				end
				brat_pkg::PH_CONV: begin
					pn = mul_add(pq, p1, p0);
					qn = mul_add(pq, q1, q0);
					if (pn > lim || qn > lim) begin
						x_phase = brat_pkg::PH_IDLE;
						push_approx('0, '0, 1'b0, 1'b0, 1'b1);
					end else begin
						p0 = p1;
						p1 = pn[W-1:0];
						q0 = q1;
						q1 = qn[W-1:0];
						nr = (r_den != 0) ? r_num % r_den : '0;
						r_num = r_den;
						r_den = nr;
						x_past_first = 1'b1;
						// remainder zero closes the run on this convergent
						x_phase = (r_den == 0) ? brat_pkg::PH_IDLE : brat_pkg::PH_DIV;
						push_approx(pn[W-1:0], qn[W-1:0], 1'b1, 1'b1, r_den == 0);
					end
				end
				default: ;  // idle step: nothing happens
			endcase
		end
	endtask

	// driver: next item goes out once the current one has been transferred
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.cmd         <= CMD_LOAD;
			in_ch.numerator   <= '0;
			in_ch.denominator <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				ratio_item_t it;
				it = pending_items.pop_front();
				in_ch.valid       <= 1'b1;
				in_ch.cmd         <= it.cmd;
				in_ch.numerator   <= it.numerator;
				in_ch.denominator <= it.denominator;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// predict on every input transfer
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			ratio_item_t it;
			it.cmd         = in_ch.cmd;
			it.numerator   = in_ch.numerator;
			it.denominator = in_ch.denominator;
			advance_expansion(it);
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			approx_t got, want;
			got.frac_num      = out_ch.frac_num;
			got.frac_den      = out_ch.frac_den;
			got.has_fraction  = out_ch.has_fraction;
			got.is_convergent = out_ch.is_convergent;
			got.final_res     = out_ch.final_res;
			if (expected_approx.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: num %0d den %0d has %0b conv %0b fin %0b",
						got.frac_num, got.frac_den, got.has_fraction,
						got.is_convergent, got.final_res);
			end else begin
				want = expected_approx.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %0d/%0d h%0b c%0b f%0b, got %0d/%0d h%0b c%0b f%0b",
							want.frac_num, want.frac_den, want.has_fraction,
							want.is_convergent, want.final_res,
							got.frac_num, got.frac_den, got.has_fraction,
							got.is_convergent, got.final_res);
				end
			end
		end
	end

	// watchdog: too long with no transfer anywhere
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("best_rational_approximation_tb: done, errors");
			$finish;
		end
	end

	task automatic queue_item(input logic c, input logic [W-1:0] n, d);
		ratio_item_t it;
		it.cmd         = c;
		it.numerator   = n;
		it.denominator = d;
		pending_items.push_back(it);
	endtask

	// value mix: mostly small, some full width, some corners
	function automatic logic [W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return '0;
			1:       return {W{1'b1}};
			2, 3:    return $urandom;
			4:       return $urandom_range(1, 3);
			default: return $urandom_range(1, 2000);
		endcase
	endfunction

	task automatic queue_run(input logic [W-1:0] n, d, input int ticks);
		queue_item(CMD_LOAD, n, d);
		repeat (ticks) queue_item(CMD_STEP, $urandom, $urandom);
	endtask

	// wait for all transfers, then let a possibly silent tick finish
	task automatic drain();
		while (pending_items.size() != 0 || in_ch.valid || expected_approx.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.limit <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		lim_reg = v;
	endtask

	initial begin
		logic [31:0] limits[8];
		int          sent;
		int unsigned ph;
		cfg_ch.valid   = 1'b0;
		cfg_ch.limit   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		expansion_reset();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle tick, zero denominator, zero numerator, extremes,
		// a ratio with semiconvergents
		queue_item(CMD_STEP, '0, '0);
		queue_run('0, '0, 2);
		queue_run(5, '0, 1);
		queue_run('0, 7, 3);
		queue_run({W{1'b1}}, 1, 3);
		queue_run(355, 113, 10);
		drain();
		write_limit(32'd100);
		queue_run(3141593, 1000000, 18);
		drain();

		limits = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd2, 32'd0, 32'd50000, 32'd0};
		limits[6] = $urandom;
		for (ph = 0; ph < 8; ph++) begin
			write_limit(limits[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			sent = 0;
			while (sent < 250) begin
				int r, ticks;
				r = $urandom_range(9);
				if (r == 0) begin
					// noise: stray ticks, mostly on an idle block
					ticks = $urandom_range(1, 4);
					repeat (ticks) queue_item(CMD_STEP, $urandom, $urandom);
				end else begin
					// well-formed run; a short tick count breaks it off early
					ticks = (r == 1) ? $urandom_range(0, 3) : $urandom_range(4, 60);
					queue_run(pick_value(), pick_value(), ticks);
					ticks++;
				end
				sent += ticks;
			end
			drain();
		end

		if (mismatch_count == 0 && expected_approx.size() == 0) begin
			$display("best_rational_approximation_tb: done, clean");
		end else begin
			$display("best_rational_approximation_tb: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
